// ===== design/bba_pkg.sv =====
`default_nettype none
package bba_pkg;

  // capacity and word geometry of the used-bit map
  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int BASE_W     = WORD_AW + BIT_W + 1;

  // field widths of the item channels and the config register
  localparam int BLK_W = 12;
  localparam int CNT_W = 13;

  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(4096);
  localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_BLOCKS);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOFREE       = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_t;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]   waddr_t;

endpackage
`default_nettype wire

// ===== design/bba_if.sv =====
`default_nettype none
// command items: allocate or free a block
interface bba_req_if;
  logic                     valid;
  logic                     ready;
  bba_pkg::cmd_t            cmd;
  logic [bba_pkg::BLK_W-1:0] block_number;

  modport source (output valid, output cmd, output block_number, input ready);
  modport sink   (input valid, input cmd, input block_number, output ready);
endinterface

// result items: granted block and status
interface bba_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [bba_pkg::BLK_W-1:0] granted_block;
  bba_pkg::status_t          status;

  modport source (output valid, output granted_block, output status, input ready);
  modport sink   (input valid, input granted_block, input status, output ready);
endinterface
`default_nettype wire

// ===== design/bba_ram.sv =====
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/block_bitmap_allocator_core.sv =====
`default_nettype none
// channel   dir  signals                              item
// req       in   valid ready cmd block_number         one alloc or free command
// rsp       out  valid ready granted_block status     one result per command
// cfg       in   cfg_we cfg_wdata                     total_blocks register
//
// a free goes from accept to result register through accept and word read,
// check and write back, and result load; a free beyond the count goes straight to result load
// an allocate scans the bitmap words (up to 128) one word per cycle, a rate set by
// the single read port of the bitmap ram; at a zero count it goes straight to result load
// reset clears per-word valid flags at once; an unwritten word reads as all free
// one command at a time; a result waiting on rsp.ready holds the next command at its end
module block_bitmap_allocator_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  bba_req_if.sink                        req,
  bba_rsp_if.source                      rsp,
  input  wire logic                      cfg_we,
  input  wire logic [bba_pkg::CNT_W-1:0] cfg_wdata
);
  import bba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FCHK,
    S_DONE
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  total_blocks;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_now;
  waddr_t            cur_w;
  logic [BLK_W-1:0]  blk;
  logic [NUM_WORDS-1:0] word_valid;
  logic              rd_valid;
  logic [BLK_W-1:0]  res_block;
  status_t           res_status;

  // ram ports
  logic   ram_we;
  waddr_t ram_waddr;
  word_t  ram_wdata;
  logic   ram_re;
  waddr_t ram_raddr;
  word_t  ram_rdata;

  // scan datapath
  word_t             word_data;
  logic [BASE_W-1:0] base;
  logic [BASE_W-1:0] left;
  logic [BASE_W-1:0] next_base;
  word_t             lim_mask;
  word_t             free_bits;
  logic [BIT_W-1:0]  pick;
  word_t             pick_mask;
  word_t             blk_mask;
  logic              req_fire;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // count clipped to capacity
  assign count_now = (total_blocks > COUNT_MAX) ? COUNT_MAX : total_blocks;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;

  // word never written since reset reads as all free
  assign word_data = rd_valid ? ram_rdata : '0;

  // limit of the scanned word to blocks below the count
  assign base      = {1'b0, cur_w, {BIT_W{1'b0}}};
  assign next_base = {({1'b0, cur_w} + 1'b1), {BIT_W{1'b0}}};
  assign left      = BASE_W'(count) - base;
  assign lim_mask  = (left >= BASE_W'(WORD_BITS)) ? '1
                   : ~({WORD_BITS{1'b1}} << left[BIT_W-1:0]);
  assign free_bits = ~word_data & lim_mask;

  // lowest clear bit
  always_comb begin
    pick = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pick = BIT_W'(i);
      end
    end
  end

  assign pick_mask = word_t'(1) << pick;
  assign blk_mask  = word_t'(1) << blk[BIT_W-1:0];

  // read port: first word at accept, next word while scanning
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (req_fire) begin
      ram_re    = 1'b1;
      ram_raddr = (req.cmd == CMD_FREE) ? WORD_AW'(req.block_number >> BIT_W) : '0;
    end else if (state == S_SCAN) begin
      ram_re    = 1'b1;
      ram_raddr = cur_w + 1'b1;
    end
  end

  // write back of the modified word
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_w;
    ram_wdata = word_data | pick_mask;
    if (state == S_SCAN) begin
      ram_we = (free_bits != '0);
    end else if (state == S_FCHK) begin
      ram_we    = ((word_data & blk_mask) != '0);
      ram_wdata = word_data & ~blk_mask;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= TOTAL_RESET;
    end else if (cfg_we) begin
      total_blocks <= cfg_wdata;
    end
  end

  // per-word valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (ram_we) begin
        word_valid[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid <= word_valid[ram_raddr];
      end
    end
  end

  // command sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      // result taken; in S_DONE the next result is loaded instead
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            count     <= count_now;
            blk       <= req.block_number;
            res_block <= '0;
            if (req.cmd == CMD_FREE) begin
              cur_w <= WORD_AW'(req.block_number >> BIT_W);
              if (CNT_W'(req.block_number) >= count_now) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else begin
                state <= S_FCHK;
              end
            end else begin
              cur_w <= '0;
              if (count_now == '0) begin
                res_status <= ST_NOFREE;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (free_bits != '0) begin
            res_block  <= BLK_W'({cur_w, pick});
            res_status <= ST_OK;
            state      <= S_DONE;
          end else if (next_base >= BASE_W'(count)) begin
            res_status <= ST_NOFREE;
            state      <= S_DONE;
          end else begin
            cur_w <= cur_w + 1'b1;
          end
        end
        S_FCHK: begin
          res_status <= ((word_data & blk_mask) != '0) ? ST_OK : ST_ALREADY_FREE;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid         <= 1'b1;
            rsp.granted_block <= res_block;
            rsp.status        <= res_status;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
module tb_top;
  import bba_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 28;
  localparam int SETTLE      = 8;

  // tracks the used-bit map and the grants and statuses still owed by the block
  class alloc_scoreboard;
    typedef struct {
      logic [BLK_W-1:0] granted;
      status_t          status;
    } grant_t;

    bit [WORD_BITS-1:0] used_map [NUM_WORDS];
    logic [CNT_W-1:0]   total_blocks;
    grant_t             owed_q [$];
    int                 errors;
    int                 commands;
    int                 status_seen [4];

    function new();
      foreach (used_map[w]) used_map[w] = '0;
      total_blocks = TOTAL_RESET;
      errors = 0;
      commands = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] value);
      total_blocks = value;
    endfunction

    // counts above capacity behave as full capacity
    function int unsigned live_count();
      int unsigned n;
      n = total_blocks;
      if (n > MAX_BLOCKS) n = MAX_BLOCKS;
      return n;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // a block below the count whose bit is set, or -1 if none
    function int pick_used_block();
      int hits [$];
      for (int n = 0; n < live_count(); n++)
        if (used_map[n / WORD_BITS][n % WORD_BITS]) hits.push_back(n);
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    // first-fit allocate or free on the local map, queue the owed result
    function void note_command(cmd_t c, logic [BLK_W-1:0] blk);
      grant_t g;
      int unsigned cnt;
      g.granted = '0;
      cnt = live_count();
      if (c == CMD_ALLOC) begin
        g.status = ST_NOFREE;
        for (int unsigned n = 0; n < cnt; n++) begin
          if (!used_map[n / WORD_BITS][n % WORD_BITS]) begin
            used_map[n / WORD_BITS][n % WORD_BITS] = 1'b1;
            g.granted = BLK_W'(n);
            g.status = ST_OK;
            break;
          end
        end
      end else if (blk >= cnt) begin
        // bits beyond the count are left alone even when set
        g.status = ST_RANGE;
      end else if (!used_map[blk / WORD_BITS][blk % WORD_BITS]) begin
        g.status = ST_ALREADY_FREE;
      end else begin
        used_map[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
        g.status = ST_OK;
      end
      status_seen[g.status]++;
      commands++;
      owed_q.push_back(g);
    endfunction

    function void check_result(logic [BLK_W-1:0] granted, status_t st);
      grant_t e;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result granted_block=%0d status=%0d", $time, granted, st);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (granted !== e.granted) begin
        $display("%0t: granted_block mismatch expected %0d actual %0d",
                 $time, e.granted, granted);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
    endfunction

    function void close_out();
      if (owed_q.size() != 0) begin
        $display("%0t: %0d results never arrived", $time, owed_q.size());
        errors += owed_q.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  bit steady;
  int stall_cycles;
  int settings_used;
  alloc_scoreboard sb;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  block_bitmap_allocator_core dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= rst ? 1'b0 : (steady || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_result(rsp_ch.granted_block, rsp_ch.status);
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, stall_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // present one command item and hold it until accepted
  task automatic send_cmd(cmd_t c, logic [BLK_W-1:0] blk);
    int gap;
    gap = 0;
    if (!steady)
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c;
    req_ch.block_number <= blk;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sb.note_command(c, blk);
  endtask

  // stop sending until every owed result is back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_block_count(logic [CNT_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_count(value);
    settings_used++;
  endtask

  // mostly allocs and frees of held blocks, plus stray and out-of-range frees
  task automatic run_phase(int items, int alloc_pct, bit hold_mid);
    int r;
    int blk;
    for (int i = 0; i < items; i++) begin
      if (hold_mid && i == items / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        send_cmd(CMD_ALLOC, BLK_W'($urandom));
      end else begin
        r = $urandom_range(0, 9);
        blk = (r < 6) ? sb.pick_used_block() : -1;
        if (blk < 0 && r < 8 && sb.live_count() > 0)
          blk = $urandom_range(0, sb.live_count() - 1);
        if (blk < 0) blk = $urandom_range(0, (1 << BLK_W) - 1);
        send_cmd(CMD_FREE, BLK_W'(blk));
      end
    end
  endtask

  initial begin
    int counts [12];
    sb = new();
    steady = 1'b0;
    settings_used = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.cmd <= CMD_ALLOC;
    req_ch.block_number <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full count after reset
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_ALLOC, '1);
    send_cmd(CMD_FREE, BLK_W'(0));
    send_cmd(CMD_FREE, BLK_W'(0));
    send_cmd(CMD_FREE, '1);
    send_cmd(CMD_ALLOC, '0);
    // zero count: nothing to allocate, every free out of range
    write_block_count(CNT_W'(0));
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_FREE, BLK_W'(0));
    send_cmd(CMD_FREE, BLK_W'(1));
    // count above capacity clamps to capacity
    write_block_count('1);
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_FREE, '1);
    // lowered count: held bits above it are out of range
    write_block_count(CNT_W'(2));
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_FREE, BLK_W'(3));
    send_cmd(CMD_FREE, BLK_W'(1));
    send_cmd(CMD_ALLOC, '0);
    write_block_count(COUNT_MAX);
    send_cmd(CMD_FREE, BLK_W'(3));

    // random phases over a spread of block counts
    counts = '{1, 5, 32, 33, 64, 0, 300, 8191, 4096, 97, 31, 1000};
    foreach (counts[p]) begin
      write_block_count(CNT_W'(counts[p]));
      steady = (p == 3);
      run_phase(56, (counts[p] >= 300) ? 75 : $urandom_range(40, 65), p == 6);
    end
    steady = 1'b0;

    drain_results();
    repeat (24) @(posedge clk);
    sb.close_out();
    $display("ran %0d commands over %0d block-count settings", sb.commands, settings_used);
    $display("grants/frees ok %0d, no free block %0d, already free %0d, out of range %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_NOFREE],
             sb.status_seen[ST_ALREADY_FREE], sb.status_seen[ST_RANGE]);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
